// File: rtl/pressure_temperature_compensation_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the compensation core
// Shared helpers for the concurrent checks on the core's ports.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH

// check that is switched off while reset is asserted
`define PTC_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// check that also covers the reset cycles
`define PTC_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/ptc_pkg.sv
// ---------------------------------------------------------------------------
// ptc_pkg
// Types and constants shared by the compensation core modules.
// ---------------------------------------------------------------------------
package ptc_pkg;

    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = 2;
    localparam int TEMP_BASE       = 250;
    localparam int OFFSET_TC_BIAS  = 1024;
    localparam int PRESS_RAW_BIAS  = 7168;
    localparam int CORR_SHIFT      = 14;
    localparam int SLOPE_SHIFT     = 16;
    localparam int OFFSET_SHIFT    = 14;
    localparam int SENS_SHIFT      = 10;
    localparam int PRESS_SHIFT     = 14;
    localparam int OUT_SHIFT       = 5;
    localparam int MAX_SHIFT       = 31;
    // divide by ten: (n * 52429) >> 19 is exact for 16-bit n
    localparam int DIV10_MUL       = 52429;
    localparam int DIV10_SHIFT     = 19;
    localparam int ADJ_Q_W         = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_BASE         = 3'd0,
        REG_OFFSET_BASE       = 3'd1,
        REG_SENS_TEMP_COEFF   = 3'd2,
        REG_OFFSET_TEMP_COEFF = 3'd3,
        REG_REF_TEMP_COUNT    = 3'd4,
        REG_TEMP_SLOPE        = 3'd5,
        REG_PRESSURE_ADJUST   = 3'd6,
        REG_CURVE_COEFFS      = 3'd7
    } cfg_idx_t;

    // calibration set as seen by the datapath
    typedef struct packed {
        logic [15:0]        sens_base;
        logic [15:0]        offset_base;
        logic [15:0]        sens_temp_coeff;
        logic [15:0]        offset_temp_coeff;
        logic [15:0]        ref_temp_count;
        logic [15:0]        temp_slope;
        logic [ADJ_Q_W-1:0] adj_div10;
        logic [7:0]         coef_a;
        logic [7:0]         coef_b;
        logic [7:0]         coef_c;
        logic [7:0]         coef_d;
    } cfg_t;

    // classified sample held in the queue
    typedef struct packed {
        logic [16:0] x;      // temp_raw - ref_temp_count, two's complement
        logic [7:0]  z;      // selected curve coefficient
        logic [15:0] d1;     // raw pressure count
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// File: rtl/ptc_front.sv
// ---------------------------------------------------------------------------
// ptc_front
// Accepts raw sample pairs, forms the temperature difference and picks the
// second-order coefficient, then pushes the result into the queue.
// ---------------------------------------------------------------------------
module ptc_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          s_pressure_raw,
    input  logic [15:0]          s_temp_raw,
    input  ptc_pkg::cfg_t        cfg,
    input  ptc_pkg::queue_stat_t q_stat,
    output logic                 push,
    output ptc_pkg::item_t       push_item
);
    import ptc_pkg::*;

    logic [16:0] diff;

    assign diff    = {1'b0, s_temp_raw} - {1'b0, cfg.ref_temp_count};
    assign s_ready = !q_stat.full;
    assign push    = s_valid && !q_stat.full;

    always_comb begin
        push_item.x  = diff;
        // negative difference means below the reference count
        push_item.z  = diff[16] ? cfg.coef_b : cfg.coef_a;
        push_item.d1 = s_pressure_raw;
    end

endmodule

// File: rtl/ptc_queue.sv
// ---------------------------------------------------------------------------
// ptc_queue
// Short queue of classified samples between front and back end.
// ---------------------------------------------------------------------------
module ptc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ptc_pkg::item_t       push_item,
    input  logic                 pop,
    output ptc_pkg::item_t       pop_item,
    output ptc_pkg::queue_stat_t q_stat
);
    import ptc_pkg::*;

    item_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/ptc_back.sv
// ---------------------------------------------------------------------------
// ptc_back
// Eight-stage compensation pipeline; the last stage is the output register.
// The whole pipe advances when the output is empty or being taken.
// ---------------------------------------------------------------------------
module ptc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptc_pkg::cfg_t        cfg,
    input  ptc_pkg::queue_stat_t q_stat,
    output logic                 pop,
    input  ptc_pkg::item_t       pop_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_temperature,
    output logic [15:0]          m_pressure
);
    import ptc_pkg::*;

    logic       adv;
    logic [7:0] vld_reg, vld_next;

    // stage registers
    logic [24:0] s1_xz_reg, s1_xz_next;
    logic [16:0] s1_x_reg;
    logic [15:0] s1_d1_reg;
    logic [31:0] s2_prod_reg, s2_prod_next;
    logic [16:0] s2_x_reg;
    logic [15:0] s2_d1_reg;
    logic [31:0] s3_biased_reg, s3_biased_next;
    logic [16:0] s3_x_reg;
    logic [15:0] s3_d1_reg;
    logic [31:0] s4_dut_reg, s4_dut_next;
    logic [15:0] s4_d1_reg;
    logic [31:0] s5_mt_reg, s5_mt_next;
    logic [31:0] s5_mo_reg, s5_mo_next;
    logic [31:0] s5_ms_reg, s5_ms_next;
    logic [15:0] s5_dsh_reg, s5_dsh_next;
    logic [15:0] s5_d1_reg;
    logic [15:0] s6_t_reg, s6_t_next;
    logic [31:0] s6_offs_reg, s6_offs_next;
    logic [31:0] s6_sens_reg, s6_sens_next;
    logic [16:0] s6_d1m_reg, s6_d1m_next;
    logic [31:0] s7_pm_reg, s7_pm_next;
    logic [15:0] s7_t_reg;
    logic [31:0] s7_offs_reg;
    logic [15:0] t_out_reg;
    logic [15:0] p_out_reg, p_out_next;

    // combinational helpers, kept signed on their own
    logic signed [25:0] xz_full;
    logic signed [31:0] xz_ext, x2_ext, corr, bias, shifted_q, x4_ext, dut_s;
    logic signed [31:0] dsh_full, mt_sh, mo_sh, ms_sh, d1m_ext, pm_sh, px, px_sh;
    logic [31:0]        c4d;
    logic [4:0]         dsh_amt;

    assign adv      = m_ready || !vld_reg[7];
    assign pop      = adv && !q_stat.empty;
    assign vld_next = {vld_reg[6:0], pop};

    // stage 1: x * z
    assign xz_full    = $signed(pop_item.x) * $signed({1'b0, pop_item.z});
    assign s1_xz_next = xz_full[24:0];

    // stage 2: (x * z) * x, wrapping at 32 bits
    assign xz_ext       = 32'($signed(s1_xz_reg));
    assign x2_ext       = 32'($signed(s1_x_reg));
    assign s2_prod_next = 32'(xz_ext * x2_ext);

    // stage 3: scale and bias negative values for round toward zero
    assign corr           = $signed(s2_prod_reg) >>> CORR_SHIFT;
    assign bias           = $signed(~(32'hFFFF_FFFF << cfg.coef_c[4:0]));
    assign s3_biased_next = corr[31] ? 32'(corr + bias) : corr;

    // stage 4: divide by 2^C, then the corrected difference
    assign shifted_q   = $signed(s3_biased_reg) >>> cfg.coef_c[4:0];
    assign x4_ext      = 32'($signed(s3_x_reg));
    assign dut_s       = (cfg.coef_c > 8'(MAX_SHIFT)) ? x4_ext : 32'(x4_ext - shifted_q);
    assign s4_dut_next = dut_s;

    // stage 5: three coefficient products in parallel
    assign c4d         = {16'b0, cfg.offset_temp_coeff} - 32'(OFFSET_TC_BIAS);
    assign s5_mt_next  = 32'(s4_dut_reg * {16'b0, cfg.temp_slope});
    assign s5_mo_next  = 32'(s4_dut_reg * c4d);
    assign s5_ms_next  = 32'(s4_dut_reg * {16'b0, cfg.sens_temp_coeff});
    assign dsh_amt     = (cfg.coef_d > 8'(MAX_SHIFT)) ? 5'(MAX_SHIFT) : cfg.coef_d[4:0];
    assign dsh_full    = $signed(s4_dut_reg) >>> dsh_amt;
    assign s5_dsh_next = dsh_full[15:0];

    // stage 6: temperature, offset and sensitivity
    assign mt_sh        = $signed(s5_mt_reg) >>> SLOPE_SHIFT;
    assign mo_sh        = $signed(s5_mo_reg) >>> OFFSET_SHIFT;
    assign ms_sh        = $signed(s5_ms_reg) >>> SENS_SHIFT;
    assign s6_t_next    = 16'(TEMP_BASE) + mt_sh[15:0] - s5_dsh_reg;
    assign s6_offs_next = ({16'b0, cfg.offset_base} + mo_sh) << 2;
    assign s6_sens_next = {16'b0, cfg.sens_base} + ms_sh;
    assign s6_d1m_next  = {1'b0, s5_d1_reg} - 17'(PRESS_RAW_BIAS);

    // stage 7: sensitivity times pressure count
    assign d1m_ext    = 32'($signed(s6_d1m_reg));
    assign s7_pm_next = 32'($signed(s6_sens_reg) * d1m_ext);

    // stage 8: pressure
    assign pm_sh      = $signed(s7_pm_reg) >>> PRESS_SHIFT;
    assign px         = 32'(pm_sh - $signed(s7_offs_reg));
    assign px_sh      = px >>> OUT_SHIFT;
    assign p_out_next = px_sh[15:0] + 16'(cfg.adj_div10);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_xz_reg     <= s1_xz_next;
            s1_x_reg      <= pop_item.x;
            s1_d1_reg     <= pop_item.d1;
            s2_prod_reg   <= s2_prod_next;
            s2_x_reg      <= s1_x_reg;
            s2_d1_reg     <= s1_d1_reg;
            s3_biased_reg <= s3_biased_next;
            s3_x_reg      <= s2_x_reg;
            s3_d1_reg     <= s2_d1_reg;
            s4_dut_reg    <= s4_dut_next;
            s4_d1_reg     <= s3_d1_reg;
            s5_mt_reg     <= s5_mt_next;
            s5_mo_reg     <= s5_mo_next;
            s5_ms_reg     <= s5_ms_next;
            s5_dsh_reg    <= s5_dsh_next;
            s5_d1_reg     <= s4_d1_reg;
            s6_t_reg      <= s6_t_next;
            s6_offs_reg   <= s6_offs_next;
            s6_sens_reg   <= s6_sens_next;
            s6_d1m_reg    <= s6_d1m_next;
            s7_pm_reg     <= s7_pm_next;
            s7_t_reg      <= s6_t_reg;
            s7_offs_reg   <= s6_offs_reg;
            t_out_reg     <= s7_t_reg;
            p_out_reg     <= p_out_next;
        end
    end

    assign m_valid       = vld_reg[7];
    assign m_temperature = t_out_reg;
    assign m_pressure    = p_out_reg;

endmodule

// File: rtl/pressure_temperature_compensation_core.sv
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_core
// Turns raw pressure and temperature counts into compensated temperature
// (0.1 degree) and pressure (0.1 hPa) from a set of calibration registers.
//
// s_ channel: one transfer carries a raw pressure / temperature pair.
// m_ channel: one transfer per input pair, in order, temperature and pressure.
// cfg port: write-only, eight registers, each written with cfg_wr_en; the
//   user makes writes while no sample is in flight; the core does not check.
// path: a result reaches m_valid once its input transfer has passed through
//   the queue and then the stages of the back-end pipeline.
// throughput: one pair per cycle unless stalled; the two chained multiplies
//   of the second-order term and the sensitivity product each own a stage.
// reset: synchronous, clears the calibration registers, the queue and all
//   pipeline valid bits; s_ready is high in the cycle after reset.
// stall: m_ready held low freezes the back end while a result waits; the
//   four-entry queue keeps taking input until it fills, then s_ready drops.
// ---------------------------------------------------------------------------
module pressure_temperature_compensation_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [15:0]                    s_pressure_raw,
    input  logic [15:0]                    s_temp_raw,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [15:0]             m_temperature,
    output logic signed [15:0]             m_pressure,
    // configuration port
    input  logic                           cfg_wr_en,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ptc_pkg::*;

    // calibration registers
    logic [15:0] sens_base_reg;
    logic [15:0] offset_base_reg;
    logic [15:0] sens_temp_coeff_reg;
    logic [15:0] offset_temp_coeff_reg;
    logic [15:0] ref_temp_count_reg;
    logic [15:0] temp_slope_reg;
    logic [15:0] pressure_adjust_reg;
    logic [31:0] curve_coeffs_reg;

    // pressure_adjust / 10, refreshed every cycle from the register
    logic [31:0]        adj_prod;
    logic [ADJ_Q_W-1:0] adj_div10_reg, adj_div10_next;

    cfg_t        cfg;
    item_t       push_item, pop_item;
    queue_stat_t q_stat;
    logic        push, pop;
    logic [15:0] temp_out, press_out;

    assign adj_prod       = 32'(pressure_adjust_reg) * 32'(DIV10_MUL);
    assign adj_div10_next = adj_prod[DIV10_SHIFT +: ADJ_Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_base_reg         <= '0;
            offset_base_reg       <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temp_count_reg    <= '0;
            temp_slope_reg        <= '0;
            pressure_adjust_reg   <= '0;
            curve_coeffs_reg      <= '0;
            adj_div10_reg         <= '0;
        end else begin
            adj_div10_reg <= adj_div10_next;
            if (cfg_wr_en) begin
                // 16-bit words take the low half of the write data
                unique case (cfg_idx_t'(cfg_addr))
                    REG_SENS_BASE:         sens_base_reg         <= cfg_wdata[15:0];
                    REG_OFFSET_BASE:       offset_base_reg       <= cfg_wdata[15:0];
                    REG_SENS_TEMP_COEFF:   sens_temp_coeff_reg   <= cfg_wdata[15:0];
                    REG_OFFSET_TEMP_COEFF: offset_temp_coeff_reg <= cfg_wdata[15:0];
                    REG_REF_TEMP_COUNT:    ref_temp_count_reg    <= cfg_wdata[15:0];
                    REG_TEMP_SLOPE:        temp_slope_reg        <= cfg_wdata[15:0];
                    REG_PRESSURE_ADJUST:   pressure_adjust_reg   <= cfg_wdata[15:0];
                    REG_CURVE_COEFFS:      curve_coeffs_reg      <= cfg_wdata;
                    default:               ;
                endcase
            end
        end
    end

    // pass the registers on and unpack the curve word into its four coefficients
    always_comb begin
        cfg.sens_base         = sens_base_reg;
        cfg.offset_base       = offset_base_reg;
        cfg.sens_temp_coeff   = sens_temp_coeff_reg;
        cfg.offset_temp_coeff = offset_temp_coeff_reg;
        cfg.ref_temp_count    = ref_temp_count_reg;
        cfg.temp_slope        = temp_slope_reg;
        cfg.adj_div10         = adj_div10_reg;
        cfg.coef_a            = curve_coeffs_reg[7:0];
        cfg.coef_b            = curve_coeffs_reg[15:8];
        cfg.coef_c            = curve_coeffs_reg[23:16];
        cfg.coef_d            = curve_coeffs_reg[31:24];
    end

    // front end: classify and push
    ptc_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pressure_raw (s_pressure_raw),
        .s_temp_raw     (s_temp_raw),
        .cfg            (cfg),
        .q_stat         (q_stat),
        .push           (push),
        .push_item      (push_item)
    );

    // decoupling queue
    ptc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    // back end: compensation pipeline with output register
    ptc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_stat        (q_stat),
        .pop           (pop),
        .pop_item      (pop_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_temperature (temp_out),
        .m_pressure    (press_out)
    );

    assign m_temperature = $signed(temp_out);
    assign m_pressure    = $signed(press_out);

endmodule

// File: rtl/ptc_checker.sv
// ---------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the compensation core, bound to the top level.
// ---------------------------------------------------------------------------
`include "pressure_temperature_compensation_core_defines.svh"

module ptc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_temperature,
    input logic signed [15:0] m_pressure
);

    logic [31:0] result_word;

    assign result_word = {m_temperature, m_pressure};

    // reset empties the pipeline
    `PTC_ASSERT_ALL(a_reset_no_result, !aresetn |=> !m_valid, "result valid after reset")

    // reset empties the queue, so input is taken right away
    `PTC_ASSERT_ALL(a_reset_ready, !aresetn |=> s_ready, "input not ready after reset")

    // nothing can reach the output straight after leaving reset
    `PTC_ASSERT_ALL(a_reset_latency, !aresetn ##1 aresetn |=> !m_valid, "result too early")

    // a stalled result stays put
    `PTC_ASSERT_RUN(a_hold_valid, m_valid && !m_ready |=> m_valid, "result dropped")
    `PTC_ASSERT_RUN(a_hold_data, m_valid && !m_ready |=> $stable(result_word), "result changed")

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (.*);

// File: test/pressure_temperature_compensation_core_tb.sv
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_core_tb
// Self-checking bench for the compensation core. Sensor pairs are pushed
// through the s_ channel and every m_ transfer is checked, in order, against
// readings computed in the bench from its own copy of the calibration
// registers. The run covers reset values, typical calibration, all-ones
// calibration, large divide and shift coefficients, then random calibration
// sets with random pairs, random idling, back-pressure and drain pauses.
// ---------------------------------------------------------------------------
module pressure_temperature_compensation_core_tb;
    import ptc_pkg::*;

    // bench time limit, far beyond the slowest passing run
    localparam int RUN_LIMIT    = 2_000_000;
    // cycles let pass after the last result before calibration is touched
    localparam int SETTLE_CYCLES = 16;
    // receiver hold-off used to fill the core and stall its input
    localparam int HOLD_CYCLES  = 64;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_PAIRS  = 85;
    localparam int MAX_REPORTS  = 10;
    localparam logic [15:0] TYP_REF = 16'd33000;

    // calibration as the core holds it
    typedef struct {
        logic [15:0] sens_base;
        logic [15:0] offset_base;
        logic [15:0] sens_temp_coeff;
        logic [15:0] offset_temp_coeff;
        logic [15:0] ref_temp_count;
        logic [15:0] temp_slope;
        logic [15:0] pressure_adjust;
        logic [31:0] curve_coeffs;
    } cal_t;

    typedef struct {
        logic [15:0] pressure_raw;
        logic [15:0] temp_raw;
    } pair_t;

    typedef struct {
        logic signed [15:0] temperature;
        logic signed [15:0] pressure;
    } reading_t;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [15:0]           s_pressure_raw = '0;
    logic [15:0]           s_temp_raw     = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic signed [15:0]    m_temperature;
    logic signed [15:0]    m_pressure;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

    cal_t     cal;                 // bench copy of the calibration registers
    pair_t    pending[$];          // pairs waiting for the driver
    reading_t readings_due[$];     // readings owed by the core, oldest first
    int       outstanding  = 0;    // pairs queued but not yet answered
    int       n_fail       = 0;
    int       src_idle_pct = 14;
    int       snk_idle_pct = 14;
    logic     hold_go      = 1'b0;
    logic     rx_hold      = 1'b0;

    pressure_temperature_compensation_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pressure_raw (s_pressure_raw),
        .s_temp_raw     (s_temp_raw),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_temperature  (m_temperature),
        .m_pressure     (m_pressure),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // compensation arithmetic, all on 32-bit wrapping words
    // ------------------------------------------------------------------

    // arithmetic right shift, saturating the count at 31
    function automatic logic [31:0] shr_arith(logic [31:0] v, int unsigned n);
        if (n > 31) n = 31;
        return $signed(v) >>> n;
    endfunction

    // signed divide by 2^n rounding toward zero; anything past 31 gives zero
    function automatic logic [31:0] div_trunc_pow2(logic [31:0] v, int unsigned n);
        logic [31:0] bias;
        if (n > 31) return 32'd0;
        if (!v[31]) return v >> n;
        bias = (32'd1 << n) - 32'd1;
        return shr_arith(v + bias, n);
    endfunction

    function automatic reading_t compensate(logic [15:0] d1, logic [15:0] d2);
        logic [31:0] coef_a, coef_b, coef_c, coef_d;
        logic [31:0] z, x, corr, dt, t, c4d, offs, sens, px, p;
        reading_t    r;
        coef_a = {24'd0, cal.curve_coeffs[7:0]};
        coef_b = {24'd0, cal.curve_coeffs[15:8]};
        coef_c = {24'd0, cal.curve_coeffs[23:16]};
        coef_d = {24'd0, cal.curve_coeffs[31:24]};
        // below the reference count the second-order term uses B, else A
        z    = (d2 < cal.ref_temp_count) ? coef_b : coef_a;
        x    = {16'd0, d2} - {16'd0, cal.ref_temp_count};
        corr = shr_arith(x * z * x, CORR_SHIFT);
        dt   = x - div_trunc_pow2(corr, coef_c);
        t    = 32'(TEMP_BASE) + shr_arith(dt * {16'd0, cal.temp_slope}, SLOPE_SHIFT)
               - shr_arith(dt, coef_d);
        c4d  = {16'd0, cal.offset_temp_coeff} - 32'(OFFSET_TC_BIAS);
        offs = ({16'd0, cal.offset_base} + shr_arith(c4d * dt, OFFSET_SHIFT)) << 2;
        sens = {16'd0, cal.sens_base}
               + shr_arith({16'd0, cal.sens_temp_coeff} * dt, SENS_SHIFT);
        px   = shr_arith(sens * ({16'd0, d1} - 32'(PRESS_RAW_BIAS)), PRESS_SHIFT) - offs;
        p    = shr_arith(px, OUT_SHIFT) + {16'd0, cal.pressure_adjust} / 32'd10;
        r.temperature = t[15:0];
        r.pressure    = p[15:0];
        return r;
    endfunction

    task automatic report_fail(string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // calibration writes, only while nothing is in flight
    // ------------------------------------------------------------------

    task automatic set_reg(cfg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        // 16-bit registers keep the low half of the write data
        case (idx)
            REG_SENS_BASE:         cal.sens_base         = value[15:0];
            REG_OFFSET_BASE:       cal.offset_base       = value[15:0];
            REG_SENS_TEMP_COEFF:   cal.sens_temp_coeff   = value[15:0];
            REG_OFFSET_TEMP_COEFF: cal.offset_temp_coeff = value[15:0];
            REG_REF_TEMP_COUNT:    cal.ref_temp_count    = value[15:0];
            REG_TEMP_SLOPE:        cal.temp_slope        = value[15:0];
            REG_PRESSURE_ADJUST:   cal.pressure_adjust   = value[15:0];
            REG_CURVE_COEFFS:      cal.curve_coeffs      = value;
            default: ;
        endcase
    endtask

    // write a whole set, with junk in the unused upper half of the 16-bit words
    task automatic load_cal(cal_t c);
        set_reg(REG_SENS_BASE,         {16'($urandom), c.sens_base});
        set_reg(REG_OFFSET_BASE,       {16'($urandom), c.offset_base});
        set_reg(REG_SENS_TEMP_COEFF,   {16'($urandom), c.sens_temp_coeff});
        set_reg(REG_OFFSET_TEMP_COEFF, {16'($urandom), c.offset_temp_coeff});
        set_reg(REG_REF_TEMP_COUNT,    {16'($urandom), c.ref_temp_count});
        set_reg(REG_TEMP_SLOPE,        {16'($urandom), c.temp_slope});
        set_reg(REG_PRESSURE_ADJUST,   {16'($urandom), c.pressure_adjust});
        set_reg(REG_CURVE_COEFFS,      c.curve_coeffs);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender pause: nothing new until every reading is back and the core is quiet
    task automatic wait_idle();
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_pair(logic [15:0] d1, logic [15:0] d2);
        pair_t pr;
        pr.pressure_raw = d1;
        pr.temp_raw     = d2;
        pending.push_back(pr);
        outstanding++;
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cal_t random_cal();
        cal_t        c;
        logic [7:0]  cc, cd;
        c.sens_base       = rand_word();
        c.offset_base     = rand_word();
        c.sens_temp_coeff = rand_word();
        // offset coefficient mostly near its 1024 bias, where it normally sits
        c.offset_temp_coeff = ($urandom_range(0, 3) == 0) ? rand_word()
                              : 16'(OFFSET_TC_BIAS + $urandom_range(0, 400) - 200);
        c.ref_temp_count  = rand_word();
        c.temp_slope      = rand_word();
        c.pressure_adjust = rand_word();
        // divide exponent mostly in its nominal 0..15, shift mostly below 32
        cc = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(16, 255))
                                         : 8'($urandom_range(0, 15));
        cd = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(32, 255))
                                         : 8'($urandom_range(0, 31));
        c.curve_coeffs = {cd, cc, 8'($urandom), 8'($urandom)};
        return c;
    endfunction

    function automatic logic [15:0] rand_pressure();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(PRESS_RAW_BIAS);
            default: return 16'($urandom);
        endcase
    endfunction

    // temperature counts clustered around the reference, plus the edges
    function automatic logic [15:0] rand_temp();
        case ($urandom_range(0, 7))
            0, 1, 2: return 16'(cal.ref_temp_count + $urandom_range(0, 4000) - 2000);
            3: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    2:       return cal.ref_temp_count;
                    default: return cal.ref_temp_count - 16'd1;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input driver: holds a pair until it transfers, then loads the next
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : pair_driver
        pair_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // the pair on the port transferred at this edge, so its reading is owed
            if (s_valid) readings_due.push_back(compensate(s_pressure_raw, s_temp_raw));
            if (pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = pending.pop_front();
                s_valid        <= 1'b1;
                s_pressure_raw <= nxt.pressure_raw;
                s_temp_raw     <= nxt.temp_raw;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: every m_ transfer against the oldest owed reading
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        reading_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                outstanding--;
                if (readings_due.size() == 0) begin
                    report_fail($sformatf("unexpected result temperature %0d pressure %0d",
                                          m_temperature, m_pressure));
                end else begin
                    want = readings_due.pop_front();
                    if (m_temperature !== want.temperature)
                        report_fail($sformatf("temperature expected %0d got %0d",
                                              want.temperature, m_temperature));
                    if (m_pressure !== want.pressure)
                        report_fail($sformatf("pressure expected %0d got %0d",
                                              want.pressure, m_pressure));
                end
            end
            m_ready <= !rx_hold && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // receiver hold-off, counted here so the sender keeps offering meanwhile
    initial begin : rx_hold_off
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin : run_limit
        #RUN_LIMIT;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        cal_t c;
        cal = '{default: '0};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration: everything zero
        push_pair(16'h0000, 16'h0000);
        push_pair(16'hFFFF, 16'hFFFF);
        push_pair(16'(PRESS_RAW_BIAS), 16'h0000);
        push_pair(16'h8000, 16'h0001);

        // typical calibration, temperature below, at and above the reference
        wait_idle();
        c.sens_base         = 16'd29112;
        c.offset_base       = 16'd26814;
        c.sens_temp_coeff   = 16'd424;
        c.offset_temp_coeff = 16'd1159;
        c.ref_temp_count    = TYP_REF;
        c.temp_slope        = 16'd2500;
        c.pressure_adjust   = 16'd9970;
        c.curve_coeffs      = {8'd9, 8'd7, 8'd10, 8'd29};
        load_cal(c);
        push_pair(16'(PRESS_RAW_BIAS), TYP_REF);
        push_pair(16'(PRESS_RAW_BIAS), TYP_REF - 16'd1);
        push_pair(16'(PRESS_RAW_BIAS), TYP_REF + 16'd1);
        push_pair(16'd30000, TYP_REF);
        push_pair(16'h0000, 16'hFFFF);
        push_pair(16'hFFFF, 16'h0000);
        push_pair(16'd7167, TYP_REF - 16'd1000);
        push_pair(16'd7169, TYP_REF + 16'd1000);
        push_pair(16'h8000, 16'h8000);
        push_pair(16'h7FFF, 16'h7FFF);
        push_pair(16'd30000, TYP_REF - 16'd15000);
        push_pair(16'd30000, TYP_REF + 16'd15000);

        // all-ones calibration: divide exponent and shift both 255
        wait_idle();
        c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'hFFFF_FFFF};
        load_cal(c);
        push_pair(16'h0000, 16'h0000);
        push_pair(16'hFFFF, 16'hFFFF);
        push_pair(16'(PRESS_RAW_BIAS), 16'hFFFE);

        // divide exponent and shift right at the 31 / 32 boundary
        wait_idle();
        c.curve_coeffs = {8'd31, 8'd31, 8'hFF, 8'hFF};
        c.ref_temp_count = 16'h8000;
        load_cal(c);
        push_pair(16'd20000, 16'h0000);
        push_pair(16'd20000, 16'hFFFF);
        wait_idle();
        set_reg(REG_CURVE_COEFFS, {8'd32, 8'd32, 8'hFF, 8'hFF});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        push_pair(16'd20000, 16'h0000);
        push_pair(16'd20000, 16'hFFFF);

        // random calibration sets with random pairs
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            load_cal(random_cal());
            // one phase runs with no idling on either side
            src_idle_pct = (ph == 3 || ph == 6) ? 0 : 14;
            snk_idle_pct = (ph == 3) ? 0 : 14;
            // one phase stalls the receiver while the sender keeps going
            if (ph == 6) hold_go = 1'b1;
            repeat (PHASE_PAIRS) push_pair(rand_pressure(), rand_temp());
        end

        wait_idle();
        if (readings_due.size() != 0)
            report_fail($sformatf("%0d readings never arrived", readings_due.size()));
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
